// ===== sv/go_back_n_sender_window_defines.svh =====
// Assertion macros for the go-back-n sender window checker.
// Included by the checker file; depends on nothing else.
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

// Checked only while the block is out of reset.
`define GBNS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GBNS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/gbns_pkg.sv =====
// Shared types, codes and defaults of the go-back-n sender window.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package gbns_pkg;

    localparam int WINDOW_MAX_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    localparam int OP_W   = 2;
    localparam int SEQ_W  = 16;
    localparam int KIND_W = 2;
    localparam int WS_W   = 5;
    localparam int TO_W   = 16;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_ACK   = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_SEND   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_WINDOW  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TOTAL   = 2'd2;

    localparam logic [WS_W-1:0]  WINDOW_RST  = 5'd4;
    localparam logic [TO_W-1:0]  TIMEOUT_RST = 16'd1000;
    localparam logic [SEQ_W-1:0] TOTAL_RST   = 16'd1;

    typedef struct packed {
        logic shift;
        logic stamp;
    } t_ring_ctl;

endpackage

// ===== sv/gbns_cell.sv =====
// One slot of the timestamp ring: holds a send time and passes it on.
// Depends on gbns_pkg for the ring control type.
`timescale 1ns / 1ps

module gbns_cell #(
    parameter int TIME_BITS = gbns_pkg::TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  gbns_pkg::t_ring_ctl   i_ring,
    input  logic [TIME_BITS-1:0]  i_now,
    input  logic [TIME_BITS-1:0]  i_ts_in,
    output logic [TIME_BITS-1:0]  o_ts
);

    logic [TIME_BITS-1:0] r_ts;
    logic [TIME_BITS-1:0] n_ts;

    assign n_ts = i_ring.stamp ? i_now : i_ts_in;
    assign o_ts = r_ts;

    always_ff @(posedge i_clk) begin
        if (i_ring.shift) begin
            r_ts <= n_ts;
        end
    end

endmodule

// ===== sv/gbns_ctrl.sv =====
// Window sequencer: configuration, window bookkeeping, ring walk and result register.
// Depends on gbns_pkg; drives the cell ring and reads its head slot.
`timescale 1ns / 1ps

module gbns_ctrl #(
    parameter int WINDOW_MAX = gbns_pkg::WINDOW_MAX_DEF,
    parameter int TIME_BITS  = gbns_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [gbns_pkg::SEQ_W-1:0]        i_s_axis_tdata,
    input  logic [gbns_pkg::OP_W:0]           i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [gbns_pkg::SEQ_W-1:0]        o_m_axis_tdata,
    output logic                              o_m_axis_tlast,
    output logic [gbns_pkg::KIND_W-1:0]       o_m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [gbns_pkg::CFG_IW-1:0]       i_cfg_index,
    input  logic [gbns_pkg::CFG_DW-1:0]       i_cfg_data,
    input  logic [TIME_BITS-1:0]              i_head_ts,
    output gbns_pkg::t_ring_ctl               o_ring,
    output logic [TIME_BITS-1:0]              o_now
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam logic [CW-1:0] LAST_J = CW'(WINDOW_MAX - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SLIDE = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                       r_state, n_state;
    logic [CW-1:0]                    r_j, n_j;
    logic [CW-1:0]                    r_cnt, n_cnt;
    logic [CW-1:0]                    r_len, n_len;
    logic [CW-1:0]                    r_slide, n_slide;
    logic [gbns_pkg::SEQ_W-1:0]       r_base, n_base;
    logic                             r_active, n_active;
    logic                             r_exp, n_exp;
    logic [TIME_BITS-1:0]             r_now, n_now;
    logic [gbns_pkg::WS_W-1:0]        r_win, n_win;
    logic [gbns_pkg::TO_W-1:0]        r_tout, n_tout;
    logic [gbns_pkg::SEQ_W-1:0]       r_total, n_total;
    logic                             r_m_valid, n_m_valid;
    logic [gbns_pkg::KIND_W-1:0]      r_kind, n_kind;
    logic [gbns_pkg::SEQ_W-1:0]       r_pkt, n_pkt;
    logic                             r_last, n_last;

    logic [gbns_pkg::OP_W-1:0]        w_op;
    logic                             w_corrupt;
    logic [gbns_pkg::SEQ_W-1:0]       w_ack;
    logic [gbns_pkg::SEQ_W-1:0]       w_eff_w;
    logic [gbns_pkg::SEQ_W-1:0]       w_eff_t;
    logic [gbns_pkg::SEQ_W-1:0]       w_len_start;
    logic [gbns_pkg::SEQ_W-1:0]       w_rem;
    logic [gbns_pkg::SEQ_W-1:0]       w_len_ack;
    logic [gbns_pkg::SEQ_W-1:0]       w_k;
    logic [TIME_BITS-1:0]             w_age;
    logic                             w_slot_free;
    logic                             w_in_sent;
    logic                             w_in_win;
    logic                             w_in_chk;
    logic                             w_want;
    logic                             w_load;

    assign w_op      = i_s_axis_tuser[gbns_pkg::OP_W-1:0];
    assign w_corrupt = i_s_axis_tuser[gbns_pkg::OP_W];
    assign w_ack     = i_s_axis_tdata;

    always_comb begin
        if (r_win == '0) begin
            w_eff_w = gbns_pkg::SEQ_W'(1);
        end else if (gbns_pkg::SEQ_W'(r_win) > gbns_pkg::SEQ_W'(WINDOW_MAX)) begin
            w_eff_w = gbns_pkg::SEQ_W'(WINDOW_MAX);
        end else begin
            w_eff_w = gbns_pkg::SEQ_W'(r_win);
        end
    end

    assign w_eff_t     = (r_total == '0) ? gbns_pkg::SEQ_W'(1) : r_total;
    assign w_len_start = (w_eff_w < w_eff_t) ? w_eff_w : w_eff_t;
    assign w_rem       = w_eff_t - w_ack;
    assign w_len_ack   = (w_eff_w < w_rem) ? w_eff_w : w_rem;
    assign w_k         = w_ack - r_base + gbns_pkg::SEQ_W'(1);
    assign w_age       = r_now - i_head_ts;
    assign w_slot_free = !r_m_valid || i_m_axis_tready;
    assign w_in_sent   = r_j < r_cnt;
    assign w_in_win    = r_j < r_len;
    assign w_in_chk    = w_in_sent && w_in_win;
    assign w_want      = w_in_win && (r_exp || !w_in_sent);

    always_comb begin
        n_state  = r_state;
        n_j      = r_j;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_slide  = r_slide;
        n_base   = r_base;
        n_active = r_active;
        n_exp    = r_exp;
        n_now    = r_now;
        n_win    = r_win;
        n_tout   = r_tout;
        n_total  = r_total;
        n_kind   = r_kind;
        n_pkt    = r_pkt;
        n_last   = r_last;
        w_load   = 1'b0;
        o_ring   = '0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                gbns_pkg::CFG_WINDOW:  n_win   = i_cfg_data[gbns_pkg::WS_W-1:0];
                gbns_pkg::CFG_TIMEOUT: n_tout  = i_cfg_data[gbns_pkg::TO_W-1:0];
                gbns_pkg::CFG_TOTAL:   n_total = i_cfg_data[gbns_pkg::SEQ_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    case (w_op)
                        gbns_pkg::OP_START: begin
                            n_active = 1'b1;
                            n_base   = gbns_pkg::SEQ_W'(1);
                            n_len    = w_len_start[CW-1:0];
                            n_cnt    = '0;
                        end
                        gbns_pkg::OP_TICK: begin
                            n_now = r_now + TIME_BITS'(1);
                            if (r_active) begin
                                n_state = S_CHECK;
                                n_j     = '0;
                                n_exp   = 1'b0;
                            end
                        end
                        gbns_pkg::OP_ACK: begin
                            if (r_active) begin
                                n_exp = 1'b0;
                                n_j   = '0;
                                if (!w_corrupt && (w_ack >= r_base)) begin
                                    if (w_ack >= w_eff_t) begin
                                        n_active = 1'b0;
                                        n_state  = S_DONE;
                                    end else begin
                                        n_base = w_ack + gbns_pkg::SEQ_W'(1);
                                        n_len  = w_len_ack[CW-1:0];
                                        if (w_k < gbns_pkg::SEQ_W'(r_cnt)) begin
                                            n_cnt   = r_cnt - w_k[CW-1:0];
                                            n_slide = w_k[CW-1:0];
                                            n_state = S_SLIDE;
                                        end else begin
                                            n_cnt   = '0;
                                            n_state = S_EMIT;
                                        end
                                    end
                                end else begin
                                    n_state = S_EMIT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                o_ring.shift = 1'b1;
                if (w_in_chk && (w_age > TIME_BITS'(r_tout))) begin
                    n_exp = 1'b1;
                end
                n_j = r_j + CW'(1);
                if (r_j == LAST_J) begin
                    n_j     = '0;
                    n_state = S_EMIT;
                end
            end
            S_SLIDE: begin
                o_ring.shift = 1'b1;
                n_slide      = r_slide - CW'(1);
                if (r_slide == CW'(1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!w_want || w_slot_free) begin
                    o_ring.shift = 1'b1;
                    o_ring.stamp = w_want;
                    if (w_want) begin
                        w_load = 1'b1;
                        n_kind = w_in_sent ? gbns_pkg::KIND_RESEND : gbns_pkg::KIND_SEND;
                        n_pkt  = r_base + gbns_pkg::SEQ_W'(r_j);
                        n_last = (r_j + CW'(1)) == r_len;
                    end
                    n_j = r_j + CW'(1);
                    if (r_j == LAST_J) begin
                        n_j     = '0;
                        n_cnt   = (r_cnt > r_len) ? r_cnt : r_len;
                        n_state = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    w_load  = 1'b1;
                    n_kind  = gbns_pkg::KIND_DONE;
                    n_pkt   = '0;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_j       <= '0;
            r_cnt     <= '0;
            r_len     <= '0;
            r_slide   <= '0;
            r_base    <= '0;
            r_active  <= 1'b0;
            r_exp     <= 1'b0;
            r_now     <= '0;
            r_win     <= gbns_pkg::WINDOW_RST;
            r_tout    <= gbns_pkg::TIMEOUT_RST;
            r_total   <= gbns_pkg::TOTAL_RST;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_j       <= n_j;
            r_cnt     <= n_cnt;
            r_len     <= n_len;
            r_slide   <= n_slide;
            r_base    <= n_base;
            r_active  <= n_active;
            r_exp     <= n_exp;
            r_now     <= n_now;
            r_win     <= n_win;
            r_tout    <= n_tout;
            r_total   <= n_total;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_pkt  <= n_pkt;
        r_last <= n_last;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_pkt;
    assign o_m_axis_tlast  = r_last;
    assign o_m_axis_tuser  = r_kind;
    assign o_now           = r_now;

endmodule

// ===== sv/go_back_n_sender_window.sv =====
// Go-back-n sender window: a start request opens a transfer, tick and acknowledgement
// requests produce send and resend commands for the packets of the window. The send time
// of each window packet sits in a ring of WINDOW_MAX cells that rotates one cell per cycle
// past the sequencer during a pass, but holds while a wanted issue waits on a full output.
// A tick during a transfer makes an age check pass and then an issue pass; an
// acknowledgement during a transfer makes an issue pass, after a slide of one cell for each
// packet the window slides while packets stay outstanding; a completing acknowledgement
// issues a done command, and a start or any request while no transfer is open walks no ring.
// Each result waits in an output register, so a stalled output holds up the issue pass. No
// clearing pass follows reset.
`timescale 1ns / 1ps

module go_back_n_sender_window #(
    parameter int WINDOW_MAX = gbns_pkg::WINDOW_MAX_DEF,
    parameter int TIME_BITS  = gbns_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // ack_number
    input  logic [gbns_pkg::SEQ_W-1:0]    i_s_axis_tdata,
    // op [1:0], ack_corrupt [2]
    input  logic [gbns_pkg::OP_W:0]       i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // pkt_num
    output logic [gbns_pkg::SEQ_W-1:0]    o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    // kind
    output logic [gbns_pkg::KIND_W-1:0]   o_m_axis_tuser,
    input  logic                          i_cfg_we,
    input  logic [gbns_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [gbns_pkg::CFG_DW-1:0]   i_cfg_data
);

    gbns_pkg::t_ring_ctl   w_ring;
    gbns_pkg::t_ring_ctl   w_cell_ctl [WINDOW_MAX];
    logic [TIME_BITS-1:0]  w_ts [WINDOW_MAX];
    logic [TIME_BITS-1:0]  w_now;

    gbns_ctrl #(
        .WINDOW_MAX (WINDOW_MAX),
        .TIME_BITS  (TIME_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_head_ts       (w_ts[0]),
        .o_ring          (w_ring),
        .o_now           (w_now)
    );

    // The tail cell takes the head's value back, or a fresh send time.
    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        assign w_cell_ctl[gi].shift = w_ring.shift;
        assign w_cell_ctl[gi].stamp = (gi == WINDOW_MAX - 1) ? w_ring.stamp : 1'b0;

        gbns_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ring  (w_cell_ctl[gi]),
            .i_now   (w_now),
            .i_ts_in (w_ts[(gi + 1) % WINDOW_MAX]),
            .o_ts    (w_ts[gi])
        );
    end

endmodule

// ===== sv/gbns_checker.sv =====
// Port-level checks for the go-back-n sender window, bound to the top level.
// Depends on gbns_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "go_back_n_sender_window_defines.svh"

module gbns_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [gbns_pkg::SEQ_W-1:0]    i_s_axis_tdata,
    input logic [gbns_pkg::OP_W:0]       i_s_axis_tuser,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [gbns_pkg::SEQ_W-1:0]    o_m_axis_tdata,
    input logic                          o_m_axis_tlast,
    input logic [gbns_pkg::KIND_W-1:0]   o_m_axis_tuser,
    input logic                          i_cfg_we,
    input logic [gbns_pkg::CFG_IW-1:0]   i_cfg_index,
    input logic [gbns_pkg::CFG_DW-1:0]   i_cfg_data
);

    logic w_quiet_req;

    // Start and reserved requests finish at once and issue nothing.
    assign w_quiet_req = i_s_axis_tvalid && o_s_axis_tready &&
                         ((i_s_axis_tuser[gbns_pkg::OP_W-1:0] == gbns_pkg::OP_START) ||
                          (i_s_axis_tuser[gbns_pkg::OP_W-1:0] == gbns_pkg::OP_RSVD));

    `GBNS_ASSERT_ALWAYS(a_ready_after_reset, !i_rst_n |=> o_s_axis_tready, "input not ready after reset")
    `GBNS_ASSERT(a_quiet_keeps_ready, w_quiet_req |=> o_s_axis_tready, "start request held the input")
    `GBNS_ASSERT(a_quiet_no_result, w_quiet_req && !o_m_axis_tvalid |=> !o_m_axis_tvalid, "start request issued a result")
    `GBNS_ASSERT(a_result_holds, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "stalled result changed")

endmodule

bind go_back_n_sender_window gbns_checker u_gbns_checker (.*);
